>>> hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int BITS_PER_WORD  = 32;
  localparam int WORD_BITS      = 5;
  localparam int FRAME_SHIFT    = 12;
  localparam int FRAME_W        = 20;
  localparam int COUNT_W        = 13;
  localparam int INDEX_W        = 12;
  localparam int DEF_MAX_FRAMES = 4096;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_MAP   = 2'd1;
  localparam op_t OP_FREE  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_SKIP  = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;
  localparam status_t STAT_RANGE = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] idx;
  } zero_find_t;

  // lowest clear bit of a bitmap word
  function automatic zero_find_t find_zero(input logic [BITS_PER_WORD-1:0] word);
    zero_find_t res;
    res = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.hit = 1'b1;
        res.idx = WORD_BITS'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Used-frame bitmap store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic [bfa_pkg::BITS_PER_WORD-1:0]  wdata,
  input  logic                               re,
  input  logic [AW-1:0]                      raddr,
  output logic [bfa_pkg::BITS_PER_WORD-1:0]  rdata
);
  import bfa_pkg::*;

  logic [BITS_PER_WORD-1:0] mem [DEPTH];
  logic [BITS_PER_WORD-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer for the allocator: clear pass, word-by-word first-fit scan and
// read-modify-write of single bitmap bits, plus the result registers.
// ----------------------------------------------------------------------------
module bfa_ctrl #(
  parameter int WORD_COUNT = 128,
  parameter int AW         = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [1:0]                         in_op,
  input  logic [31:0]                        in_page_entry,
  input  logic [31:0]                        in_map_addr,
  input  logic [bfa_pkg::COUNT_W-1:0]        limit,
  output logic                               busy,
  output logic                               out_valid,
  output logic [31:0]                        out_new_entry,
  output logic [bfa_pkg::INDEX_W-1:0]        out_frame_index,
  output logic [1:0]                         out_status,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [bfa_pkg::BITS_PER_WORD-1:0]  ram_wdata,
  output logic                               ram_re,
  output logic [AW-1:0]                      ram_raddr,
  input  logic [bfa_pkg::BITS_PER_WORD-1:0]  ram_rdata
);
  import bfa_pkg::*;

  localparam int CMPW = (AW + WORD_BITS + 1 > COUNT_W) ? AW + WORD_BITS + 1 : COUNT_W;

  state_t state_r, state_nxt;

  logic [AW-1:0]      clr_w_r, clr_w_nxt;
  logic [AW:0]        rd_w_r, rd_w_nxt;
  logic [AW-1:0]      chk_w_r, chk_w_nxt;
  logic               pend_r, pend_nxt;
  logic [31:0]        entry_r, entry_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               set_r, set_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_new_entry_r, out_new_entry_nxt;
  logic [INDEX_W-1:0]   out_frame_index_r, out_frame_index_nxt;
  status_t              out_status_r, out_status_nxt;

  logic                 accept;
  logic [FRAME_W-1:0]   in_field;
  logic [FRAME_W-1:0]   map_frame;
  logic                 map_in_range;
  logic                 free_in_range;
  logic                 clr_last;
  zero_find_t           zf;
  logic [AW+WORD_BITS-1:0] cand;
  logic [FRAME_W-1:0]   cand_frame;
  logic                 scan_hit;
  logic                 cand_ok;
  logic                 rd_more;
  logic [WORD_BITS-1:0] bit_pos;

  assign accept        = start && (state_r == ST_IDLE);
  assign in_field      = in_page_entry[31:FRAME_SHIFT];
  assign map_frame     = in_map_addr[31:FRAME_SHIFT];
  assign map_in_range  = map_frame < FRAME_W'(limit);
  assign free_in_range = in_field < FRAME_W'(limit);
  assign clr_last      = clr_w_r == AW'(WORD_COUNT - 1);
  assign zf            = find_zero(ram_rdata);
  assign cand          = {chk_w_r, zf.idx};
  assign cand_frame    = FRAME_W'(cand);
  assign scan_hit      = pend_r && zf.hit;
  assign cand_ok       = CMPW'(cand) < CMPW'(limit);
  assign rd_more       = CMPW'({rd_w_r, {WORD_BITS{1'b0}}}) < CMPW'(limit);
  assign bit_pos       = frame_r[WORD_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ALLOC: if (in_field == '0) state_nxt = ST_SCAN;
            OP_MAP:   if (in_field == '0 && map_in_range) state_nxt = ST_RD;
            OP_FREE:  if (in_field != '0 && free_in_range) state_nxt = ST_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit || !rd_more) state_nxt = ST_IDLE;
      end
      ST_RD:   state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_w_nxt           = clr_w_r;
    rd_w_nxt            = rd_w_r;
    chk_w_nxt           = chk_w_r;
    pend_nxt            = 1'b0;
    entry_nxt           = entry_r;
    frame_nxt           = frame_r;
    set_nxt             = set_r;
    out_valid_nxt       = 1'b0;
    out_new_entry_nxt   = out_new_entry_r;
    out_frame_index_nxt = out_frame_index_r;
    out_status_nxt      = out_status_r;
    ram_we              = 1'b0;
    ram_waddr           = chk_w_r;
    ram_wdata           = '0;
    ram_re              = 1'b0;
    ram_raddr           = rd_w_r[AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_w_r;
        clr_w_nxt = clr_w_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          entry_nxt           = in_page_entry;
          rd_w_nxt            = '0;
          out_new_entry_nxt   = in_page_entry;
          out_frame_index_nxt = '0;
          out_status_nxt      = STAT_SKIP;
          case (in_op)
            OP_ALLOC: begin
              if (in_field != '0) out_valid_nxt = 1'b1;
            end
            OP_MAP: begin
              frame_nxt = map_frame;
              set_nxt   = 1'b1;
              if (in_field != '0) begin
                out_valid_nxt = 1'b1;
              end else if (!map_in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_RANGE;
              end
            end
            OP_FREE: begin
              frame_nxt = in_field;
              set_nxt   = 1'b0;
              if (in_field == '0) begin
                out_valid_nxt = 1'b1;
              end else if (!free_in_range) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_RANGE;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          out_valid_nxt     = 1'b1;
          out_new_entry_nxt = entry_r;
          out_status_nxt    = STAT_FULL;
          if (cand_ok) begin
            ram_we              = 1'b1;
            ram_waddr           = chk_w_r;
            ram_wdata           = ram_rdata | (BITS_PER_WORD'(1) << zf.idx);
            out_new_entry_nxt   = {cand_frame, entry_r[FRAME_SHIFT-1:0]};
            out_frame_index_nxt = cand_frame[INDEX_W-1:0];
            out_status_nxt      = STAT_DONE;
          end
        end else if (rd_more) begin
          ram_re    = 1'b1;
          ram_raddr = rd_w_r[AW-1:0];
          chk_w_nxt = rd_w_r[AW-1:0];
          rd_w_nxt  = rd_w_r + (AW+1)'(1);
          pend_nxt  = 1'b1;
        end else begin
          out_valid_nxt     = 1'b1;
          out_new_entry_nxt = entry_r;
          out_status_nxt    = STAT_FULL;
        end
      end
      ST_RD: begin
        ram_re    = 1'b1;
        ram_raddr = frame_r[AW+WORD_BITS-1:WORD_BITS];
      end
      ST_MOD: begin
        ram_we              = 1'b1;
        ram_waddr           = frame_r[AW+WORD_BITS-1:WORD_BITS];
        ram_wdata           = set_r ? (ram_rdata | (BITS_PER_WORD'(1) << bit_pos))
                                    : (ram_rdata & ~(BITS_PER_WORD'(1) << bit_pos));
        out_valid_nxt       = 1'b1;
        out_new_entry_nxt   = set_r ? {frame_r, entry_r[FRAME_SHIFT-1:0]}
                                    : {{FRAME_W{1'b0}}, entry_r[FRAME_SHIFT-1:0]};
        out_frame_index_nxt = frame_r[INDEX_W-1:0];
        out_status_nxt      = STAT_DONE;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_w_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_w_r            <= rd_w_nxt;
    chk_w_r           <= chk_w_nxt;
    entry_r           <= entry_nxt;
    frame_r           <= frame_nxt;
    set_r             <= set_nxt;
    out_new_entry_r   <= out_new_entry_nxt;
    out_frame_index_r <= out_frame_index_nxt;
    out_status_r      <= out_status_nxt;
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_new_entry   = out_new_entry_r;
  assign out_frame_index = out_frame_index_r;
  assign out_status      = out_status_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("bitmap read and write in the same cycle");

  a_mod_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |=> out_valid_r && (out_status_r == STAT_DONE))
    else $error("bit update without a done result");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_DONE)) |-> (out_frame_index_r == '0))
    else $error("failed result carries a frame index");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN) && $past(ram_re))
    else $error("scan word pending outside the scan");

endmodule

>>> hdl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical page-frame allocator over a used-frame bitmap.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one word per cycle with busy high; cfg
// writes are taken at any time. An item is taken when start is high and
// busy is low. Skipped and out-of-range items give their result on out_valid
// the next cycle; map and free read the bitmap word, write it back and then
// give the result. Allocate scans the bitmap one 32-bit word per cycle
// through the single bitmap read port, reading no word past the frame count.
// Each result is shown for exactly one cycle with out_valid and cannot be
// stalled.
module bitmap_frame_allocator #(
  parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_page_entry,
  input  logic [31:0]                  in_map_addr,
  output logic                         out_valid,
  output logic [31:0]                  out_new_entry,
  output logic [bfa_pkg::INDEX_W-1:0]  out_frame_index,
  output logic [1:0]                   out_status,
  input  logic                         cfg_we,
  input  logic [bfa_pkg::COUNT_W-1:0]  cfg_wdata
);
  import bfa_pkg::*;

  localparam int WORD_COUNT = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [COUNT_W-1:0]       frame_count_r;
  logic [COUNT_W-1:0]       limit;
  logic                     over_cap;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [BITS_PER_WORD-1:0] ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [BITS_PER_WORD-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  // clamp the count to the bitmap capacity
  assign over_cap = 21'(frame_count_r) > 21'(MAX_FRAMES);
  assign limit    = over_cap ? COUNT_W'(MAX_FRAMES) : frame_count_r;

  bfa_ctrl #(
    .WORD_COUNT (WORD_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_op           (in_op),
    .in_page_entry   (in_page_entry),
    .in_map_addr     (in_map_addr),
    .limit           (limit),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_new_entry   (out_new_entry),
    .out_frame_index (out_frame_index),
    .out_status      (out_status),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  bfa_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap frame allocator. Items are driven
// through the start/busy handshake and each one is run through a local model
// of the used-frame bitmap and frame count at the moment it is taken. Every
// result strobe is compared field by field with the oldest predicted entry.
// Directed items cover field extremes, every op and the skip, full and
// out-of-range cases. Random phases then vary the frame count and sender
// idling, mostly as allocate/map/free sequences on real entries.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int  MAX_FRAMES  = DEF_MAX_FRAMES;
  localparam int  STALL_LIMIT = 5000;
  localparam op_t OP_SPARE    = 2'd3;

  typedef struct packed {
    logic [31:0]        entry;
    logic [INDEX_W-1:0] index;
    status_t            status;
  } alloc_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  op_t                in_op;
  logic [31:0]        in_page_entry;
  logic [31:0]        in_map_addr;
  logic               out_valid;
  logic [31:0]        out_new_entry;
  logic [INDEX_W-1:0] out_frame_index;
  status_t            out_status;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  logic [MAX_FRAMES-1:0] frame_used;
  int                    frame_count_cfg;
  alloc_result_t         pending_results[$];
  logic [31:0]           held_entries[$];
  int                    pending;
  int                    err_count;
  int                    idle_pct;
  int                    stall_cycles;
  int                    n_items, n_done, n_skip, n_full, n_range, n_settings;

  bitmap_frame_allocator #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_page_entry  (in_page_entry),
    .in_map_addr    (in_map_addr),
    .out_valid      (out_valid),
    .out_new_entry  (out_new_entry),
    .out_frame_index(out_frame_index),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int active_limit();
    return (frame_count_cfg > MAX_FRAMES) ? MAX_FRAMES : frame_count_cfg;
  endfunction

  function automatic alloc_result_t allocator_outcome(op_t op, logic [31:0] entry,
                                                      logic [31:0] addr);
    alloc_result_t r;
    int            lim;
    int            fr;
    bit            found;
    logic [19:0]   fnum;
    lim      = active_limit();
    r.entry  = entry;
    r.index  = '0;
    r.status = STAT_SKIP;
    found    = 1'b0;
    fr       = 0;
    case (op)
      OP_ALLOC: begin
        if (entry[31:12] == 20'd0) begin
          for (int f = 0; f < lim && !found; f++) begin
            if (!frame_used[f]) begin
              found = 1'b1;
              fr    = f;
            end
          end
          if (found) begin
            frame_used[fr] = 1'b1;
            r.entry        = {20'(fr), entry[11:0]};
            r.index        = INDEX_W'(fr);
            r.status       = STAT_DONE;
          end else begin
            r.status = STAT_FULL;
          end
        end
      end
      OP_MAP: begin
        if (entry[31:12] == 20'd0) begin
          fnum = addr[31:12];
          if (int'(fnum) >= lim) begin
            r.status = STAT_RANGE;
          end else begin
            frame_used[fnum] = 1'b1;
            r.entry          = {fnum, entry[11:0]};
            r.index          = fnum[INDEX_W-1:0];
            r.status         = STAT_DONE;
          end
        end
      end
      OP_FREE: begin
        if (entry[31:12] != 20'd0) begin
          fnum = entry[31:12];
          if (int'(fnum) >= lim) begin
            r.status = STAT_RANGE;
          end else begin
            frame_used[fnum] = 1'b0;
            r.entry          = {20'd0, entry[11:0]};
            r.index          = fnum[INDEX_W-1:0];
            r.status         = STAT_DONE;
          end
        end
      end
      default: r.status = STAT_SKIP;
    endcase
    n_items++;
    case (r.status)
      STAT_DONE:  n_done++;
      STAT_SKIP:  n_skip++;
      STAT_FULL:  n_full++;
      default:    n_range++;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("MISMATCH %s: expected 0x%08h got 0x%08h at %0t", what, exp_v, got_v, $time);
    err_count++;
  endtask

  task automatic send_item(input op_t op, input logic [31:0] entry, input logic [31:0] addr,
                           output alloc_result_t res);
    @(negedge clk);
    start         <= 1'b1;
    in_op         <= op;
    in_page_entry <= entry;
    in_map_addr   <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    res = allocator_outcome(op, entry, addr);
    pending_results.push_back(res);
    pending++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(40, 1) - 1) @(negedge clk);
    end
  endtask

  // drop start and hold until every predicted result has arrived
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_frame_count(int value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    @(negedge clk) cfg_we <= 1'b0;
    frame_count_cfg = value;
    n_settings++;
  endtask

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 32'd0, out_new_entry);
      end else begin
        exp_r = pending_results.pop_front();
        pending--;
        if (out_new_entry !== exp_r.entry)
          report_mismatch("new_entry", exp_r.entry, out_new_entry);
        if (out_frame_index !== exp_r.index)
          report_mismatch("frame_index", 32'(exp_r.index), 32'(out_frame_index));
        if (out_status !== exp_r.status)
          report_mismatch("status", 32'(exp_r.status), 32'(out_status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_directed();
    alloc_result_t r;
    send_item(OP_ALLOC, 32'h0000_0FFF, 32'h0000_0000, r);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, r);
    send_item(OP_MAP,   32'h0000_0ABC, 32'h00FF_FFFF, r);
    send_item(OP_MAP,   32'h1234_5000, 32'h0000_0000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h0000_0FFF, 32'h0000_0000, r);
    send_item(OP_FREE,  32'hFFFF_FFFF, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h00FF_F123, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h00FF_F000, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h0000_1555, 32'h0000_0000, r);
    send_item(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
    send_item(OP_SPARE, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'h0100_0000, r);
    send_item(OP_MAP,   32'h0000_0555, 32'h00FF_F000, r);
    send_item(OP_ALLOC, 32'h0000_0AAA, 32'h5555_5555, r);
    send_item(OP_FREE,  32'h0000_0001, 32'hAAAA_AAAA, r);
    drain();
  endtask

  task automatic test_count_extremes();
    alloc_result_t r;
    set_frame_count(0);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h0000_1000, 32'h0000_0000, r);
    set_frame_count(8191);
    send_item(OP_MAP,   32'h0000_0000, 32'h00FF_F000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'h0100_0000, r);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    set_frame_count(1);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h0000_1000, 32'h0000_0000, r);
    send_item(OP_MAP,   32'h0000_0000, 32'h0000_0FFF, r);
    set_frame_count(MAX_FRAMES);
  endtask

  // fill a count that ends inside a bitmap word, then reopen holes
  task automatic test_bitmap_full();
    alloc_result_t r;
    bit            full_seen;
    full_seen = 1'b0;
    set_frame_count(40);
    for (int k = 0; k < 45 && !full_seen; k++) begin
      send_item(OP_ALLOC, {20'd0, 12'($urandom)}, $urandom, r);
      full_seen = (r.status == STAT_FULL);
    end
    send_item(OP_FREE,  32'h0002_7000, 32'h0000_0000, r);
    send_item(OP_FREE,  32'h0002_1000, 32'h0000_0000, r);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    send_item(OP_ALLOC, 32'h0000_0000, 32'h0000_0000, r);
    drain();
  endtask

  task automatic random_item();
    alloc_result_t r;
    int            pick;
    int            lim;
    int            k;
    logic [31:0]   entry;
    logic [31:0]   addr;
    op_t           op;
    pick  = $urandom_range(99);
    lim   = active_limit();
    entry = {20'd0, 12'($urandom)};
    addr  = $urandom;
    op    = OP_ALLOC;
    if (pick < 40) begin
      op = OP_ALLOC;
    end else if (pick < 55) begin
      op = OP_MAP;
      if (lim != 0) addr = {20'($urandom_range(lim - 1)), 12'($urandom)};
    end else if (pick < 80) begin
      op = OP_FREE;
      if (held_entries.size() != 0) begin
        k     = $urandom_range(held_entries.size() - 1);
        entry = held_entries[k];
        held_entries.delete(k);
      end else begin
        entry = {20'($urandom_range(MAX_FRAMES - 1, 1)), 12'($urandom)};
      end
    end else if (pick < 88) begin
      op    = op_t'($urandom_range(3));
      entry = $urandom;
    end else if (pick < 94) begin
      op    = $urandom_range(1) ? OP_ALLOC : OP_MAP;
      entry = {20'($urandom_range(20'hFFFFF, 1)), 12'($urandom)};
    end else if ($urandom_range(1)) begin
      op = OP_MAP;
    end else begin
      op    = OP_FREE;
      entry = $urandom;
    end
    send_item(op, entry, addr, r);
    if (r.status == STAT_DONE && (op == OP_ALLOC || op == OP_MAP))
      held_entries.push_back(r.entry);
  endtask

  task automatic test_random();
    int counts[6];
    int idles[6];
    counts = '{MAX_FRAMES, 8191, 96, 33, 2500, 0};
    idles  = '{0, 60, 25, 0, 60, 25};
    counts[5] = $urandom_range(8191);
    for (int p = 0; p < 6; p++) begin
      set_frame_count(counts[p]);
      idle_pct = idles[p];
      repeat (220) begin
        random_item();
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_ALLOC;
    in_page_entry   = '0;
    in_map_addr     = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = FRAME_COUNT_RST;
    frame_used      = '0;
    frame_count_cfg = int'(FRAME_COUNT_RST);
    pending         = 0;
    err_count       = 0;
    idle_pct        = 0;
    n_items         = 0;
    n_done          = 0;
    n_skip          = 0;
    n_full          = 0;
    n_range         = 0;
    n_settings      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_count_extremes();
    test_bitmap_full();
    test_random();

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("items left without result", 32'd0, 32'(pending_results.size()));
    $display("Covered %0d items: %0d done, %0d skipped, %0d full, %0d out of range",
             n_items, n_done, n_skip, n_full, n_range);
    $display("Frame count written %0d times, including 0, 1 and 8191", n_settings);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bfa_pkg.sv
hdl/bfa_ram.sv
hdl/bfa_ctrl.sv
hdl/bitmap_frame_allocator.sv
bench/tb_top.sv
